// File: hw/rtl/can_telemetry_frame_decoder_defines.svh
// ----------------------------------------------------------------------------
// CAN telemetry frame decoder assertion macros
// Shared property wrappers used by the decoder modules.
// ----------------------------------------------------------------------------
`ifndef CAN_TELEMETRY_FRAME_DECODER_DEFINES_SVH
`define CAN_TELEMETRY_FRAME_DECODER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CTFD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ctfd assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define CTFD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ctfd assertion failed");

`endif

// File: hw/rtl/ctfd_pkg.sv
// ----------------------------------------------------------------------------
// CAN telemetry frame decoder package
// Types, register indexes and constants shared by the decoder modules.
// ----------------------------------------------------------------------------
package ctfd_pkg;

  localparam logic [28:0] CHARGER_ID_A        = 29'd0;
  localparam logic [28:0] CHARGER_ID_B        = 29'd0;
  localparam logic [28:0] BMS_FLAG_ID         = 29'd0;
  localparam logic [31:0] STATS_PERIOD_MS     = 32'd1000;
  localparam logic [7:0]  DEFAULT_TEMPERATURE = 8'd0;

  localparam logic [3:0] DLC_MIN_VOLT_CURR = 4'd8;
  localparam logic [3:0] DLC_MIN_CTRL_MOT  = 4'd6;
  localparam logic [3:0] DLC_MIN_BATT      = 4'd1;

  localparam int unsigned CFG_DATA_W = 29;

  typedef enum logic [2:0] {
    CFG_VOLT_CURR_ID  = 3'd0,
    CFG_CTRL_MOTOR_ID = 3'd1,
    CFG_BATT_TEMP_ID  = 3'd2,
    CFG_ORIG_CHG_ID   = 3'd3,
    CFG_DEADZONE      = 3'd4,
    CFG_CHG_TIMEOUT   = 3'd5,
    CFG_AUTO_CHG_EN   = 3'd6
  } cfg_idx_t;

  typedef enum logic {
    OP_FRAME = 1'b0,
    OP_TICK  = 1'b1
  } op_t;

  typedef struct packed {
    logic [28:0] voltage_current_id;
    logic [28:0] controller_motor_id;
    logic [28:0] battery_temp_id;
    logic [28:0] original_charger_id;
    logic [9:0]  current_deadzone;
    logic [19:0] orig_timeout_ms;
    logic        auto_charging_enable;
  } cfg_t;

  typedef struct packed {
    op_t         operation;
    logic [28:0] can_id;
    logic [3:0]  dlc;
    logic [7:0]  byte0;
    logic [7:0]  byte1;
    logic [7:0]  byte2;
    logic [7:0]  byte3;
    logic [7:0]  byte4;
    logic [7:0]  byte5;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        voltage_decivolts;
    logic signed [15:0] current_deciamps;
    logic               current_positive;
    logic [7:0]         temp_controller;
    logic [7:0]         temp_motor;
    logic [7:0]         temp_battery;
    logic [7:0]         mode_byte;
    logic               charger_seen;
    logic               original_charger_present;
    logic               charging_mode;
    logic [31:0]        frame_total;
    logic [31:0]        frames_per_period;
  } out_item_t;

endpackage

// File: hw/rtl/ctfd_cfg_regs.sv
// ----------------------------------------------------------------------------
// CAN telemetry frame decoder configuration registers
// Holds the identifier, deadzone, timeout and enable values.
// ----------------------------------------------------------------------------
module ctfd_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [2:0]                        cfg_index,
  input  logic [ctfd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output ctfd_pkg::cfg_t                    cfg
);

  ctfd_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (ctfd_pkg::cfg_idx_t'(cfg_index))
        ctfd_pkg::CFG_VOLT_CURR_ID:  cfg_r.voltage_current_id   <= cfg_wdata;
        ctfd_pkg::CFG_CTRL_MOTOR_ID: cfg_r.controller_motor_id  <= cfg_wdata;
        ctfd_pkg::CFG_BATT_TEMP_ID:  cfg_r.battery_temp_id      <= cfg_wdata;
        ctfd_pkg::CFG_ORIG_CHG_ID:   cfg_r.original_charger_id  <= cfg_wdata;
        ctfd_pkg::CFG_DEADZONE:      cfg_r.current_deadzone     <= cfg_wdata[9:0];
        ctfd_pkg::CFG_CHG_TIMEOUT:   cfg_r.orig_timeout_ms      <= cfg_wdata[19:0];
        ctfd_pkg::CFG_AUTO_CHG_EN:   cfg_r.auto_charging_enable <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// File: hw/rtl/ctfd_core.sv
// ----------------------------------------------------------------------------
// CAN telemetry frame decoder core
// Telemetry state registers and the single-pass frame and tick update.
// ----------------------------------------------------------------------------
`include "can_telemetry_frame_decoder_defines.svh"

module ctfd_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  ctfd_pkg::in_item_t  item,
  input  ctfd_pkg::cfg_t      cfg,
  output ctfd_pkg::out_item_t result
);

  logic [31:0] now_r, now_nxt;
  logic [31:0] stats_start_r, stats_start_nxt;
  logic [31:0] period_cnt_r, period_cnt_nxt;
  logic [31:0] total_cnt_r, total_cnt_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [31:0] last_orig_r, last_orig_nxt;
  logic [15:0] voltage_r, voltage_nxt;
  logic [15:0] current_r, current_nxt;
  logic        positive_r, positive_nxt;
  logic [7:0]  ctrl_temp_r, ctrl_temp_nxt;
  logic [7:0]  motor_temp_r, motor_temp_nxt;
  logic [7:0]  batt_temp_r, batt_temp_nxt;
  logic [7:0]  mode_r, mode_nxt;
  logic        any_chg_r, any_chg_nxt;
  logic        orig_r, orig_nxt;
  logic        charge_r, charge_nxt;

  logic [31:0] now_inc;
  logic [31:0] stats_elapsed;
  logic [31:0] orig_elapsed;
  logic [15:0] raw_curr;
  logic [15:0] curr_mag;
  logic [15:0] curr_kept;
  logic        orig_hit;
  logic        other_chg_hit;

  assign now_inc       = now_r + 32'd1;
  assign stats_elapsed = now_inc - stats_start_r;
  assign orig_elapsed  = now_inc - last_orig_r;
  assign raw_curr      = {item.byte2, item.byte3};
  assign curr_mag      = raw_curr[15] ? (~raw_curr + 16'd1) : raw_curr;
  assign curr_kept     = (curr_mag < {6'd0, cfg.current_deadzone}) ? 16'd0 : raw_curr;
  assign orig_hit      = (item.can_id == cfg.original_charger_id);
  assign other_chg_hit = (item.can_id == ctfd_pkg::CHARGER_ID_A) ||
                         (item.can_id == ctfd_pkg::CHARGER_ID_B) ||
                         (item.can_id == ctfd_pkg::BMS_FLAG_ID);

  always_comb begin
    now_nxt         = now_r;
    stats_start_nxt = stats_start_r;
    period_cnt_nxt  = period_cnt_r;
    total_cnt_nxt   = total_cnt_r;
    rate_nxt        = rate_r;
    last_orig_nxt   = last_orig_r;
    voltage_nxt     = voltage_r;
    current_nxt     = current_r;
    positive_nxt    = positive_r;
    ctrl_temp_nxt   = ctrl_temp_r;
    motor_temp_nxt  = motor_temp_r;
    batt_temp_nxt   = batt_temp_r;
    mode_nxt        = mode_r;
    any_chg_nxt     = any_chg_r;
    orig_nxt        = orig_r;
    charge_nxt      = charge_r;

    if (item.operation == ctfd_pkg::OP_TICK) begin
      now_nxt = now_inc;
      if (stats_elapsed >= ctfd_pkg::STATS_PERIOD_MS) begin
        rate_nxt        = period_cnt_r;
        period_cnt_nxt  = 32'd0;
        stats_start_nxt = now_inc;
      end
      if (orig_r && (orig_elapsed > {12'd0, cfg.orig_timeout_ms})) begin
        orig_nxt   = 1'b0;
        charge_nxt = 1'b0;
      end
    end else begin
      total_cnt_nxt  = total_cnt_r + 32'd1;
      period_cnt_nxt = period_cnt_r + 32'd1;
      if (orig_hit) begin
        orig_nxt      = 1'b1;
        last_orig_nxt = now_r;
        if (cfg.auto_charging_enable) begin
          charge_nxt = 1'b1;
        end
      end else if (other_chg_hit) begin
        any_chg_nxt = 1'b1;
      end
      // A charger id that matches no data id falls through every test below.
      if ((item.can_id == cfg.voltage_current_id) &&
          (item.dlc >= ctfd_pkg::DLC_MIN_VOLT_CURR)) begin
        voltage_nxt  = {item.byte0, item.byte1};
        current_nxt  = curr_kept;
        positive_nxt = (curr_kept != 16'd0) && !curr_kept[15];
      end else if ((item.can_id == cfg.controller_motor_id) &&
                   (item.dlc >= ctfd_pkg::DLC_MIN_CTRL_MOT)) begin
        ctrl_temp_nxt  = item.byte4;
        motor_temp_nxt = item.byte5;
        mode_nxt       = item.byte1;
      end else if ((item.can_id == cfg.battery_temp_id) &&
                   (item.dlc >= ctfd_pkg::DLC_MIN_BATT)) begin
        batt_temp_nxt = item.byte0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r         <= '0;
      stats_start_r <= '0;
      period_cnt_r  <= '0;
      total_cnt_r   <= '0;
      rate_r        <= '0;
      last_orig_r   <= '0;
      voltage_r     <= '0;
      current_r     <= '0;
      positive_r    <= 1'b0;
      ctrl_temp_r   <= ctfd_pkg::DEFAULT_TEMPERATURE;
      motor_temp_r  <= ctfd_pkg::DEFAULT_TEMPERATURE;
      batt_temp_r   <= ctfd_pkg::DEFAULT_TEMPERATURE;
      mode_r        <= '0;
      any_chg_r     <= 1'b0;
      orig_r        <= 1'b0;
      charge_r      <= 1'b0;
    end else if (step_en) begin
      now_r         <= now_nxt;
      stats_start_r <= stats_start_nxt;
      period_cnt_r  <= period_cnt_nxt;
      total_cnt_r   <= total_cnt_nxt;
      rate_r        <= rate_nxt;
      last_orig_r   <= last_orig_nxt;
      voltage_r     <= voltage_nxt;
      current_r     <= current_nxt;
      positive_r    <= positive_nxt;
      ctrl_temp_r   <= ctrl_temp_nxt;
      motor_temp_r  <= motor_temp_nxt;
      batt_temp_r   <= batt_temp_nxt;
      mode_r        <= mode_nxt;
      any_chg_r     <= any_chg_nxt;
      orig_r        <= orig_nxt;
      charge_r      <= charge_nxt;
    end
  end

  always_comb begin
    result.voltage_decivolts        = voltage_nxt;
    result.current_deciamps         = current_nxt;
    result.current_positive         = positive_nxt;
    result.temp_controller          = ctrl_temp_nxt;
    result.temp_motor               = motor_temp_nxt;
    result.temp_battery             = batt_temp_nxt;
    result.mode_byte                = mode_nxt;
    result.charger_seen             = any_chg_nxt;
    result.original_charger_present = orig_nxt;
    result.charging_mode            = charge_nxt;
    result.frame_total              = total_cnt_nxt;
    result.frames_per_period        = rate_nxt;
  end

  `CTFD_ASSERT_SAME(a_charge_needs_orig, charge_r, orig_r)
  `CTFD_ASSERT_NEXT(a_tick_keeps_total, step_en && (item.operation == ctfd_pkg::OP_TICK),
                    total_cnt_r == $past(total_cnt_r))

endmodule

// File: hw/rtl/can_telemetry_frame_decoder.sv
// ----------------------------------------------------------------------------
// CAN telemetry frame decoder
// Result path: an accepted request is held in the input register, and the
// result register loads from it once the result register is free or taken.
// Throughput: one request per cycle; the input register and the result
// register each advance whenever the result register is free or taken.
// Reset: synchronous, active low; clears all configuration registers, counters
// and flags, and the temperatures return to their default value.
// ----------------------------------------------------------------------------
`include "can_telemetry_frame_decoder_defines.svh"

module can_telemetry_frame_decoder (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  ctfd_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output ctfd_pkg::out_item_t              out_data,
  input  logic                             cfg_we,
  input  logic [2:0]                       cfg_index,
  input  logic [ctfd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  ctfd_pkg::cfg_t      cfg;
  ctfd_pkg::in_item_t  s1_item_r;
  ctfd_pkg::out_item_t out_data_r;
  ctfd_pkg::out_item_t result;
  logic                s1_valid_r;
  logic                out_valid_r;
  logic                s1_go;

  assign s1_go    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_go;

  ctfd_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ctfd_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (s1_go),
    .item    (s1_item_r),
    .cfg     (cfg),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_data;
    end
    if (s1_go) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `CTFD_ASSERT_SAME(a_ready_when_out_free, !out_valid_r, in_ready)
  `CTFD_ASSERT_NEXT(a_frame_counts_once,
                    s1_go && (s1_item_r.operation == ctfd_pkg::OP_FRAME) && out_valid_r,
                    out_data_r.frame_total == $past(out_data_r.frame_total) + 32'd1)
  `CTFD_ASSERT_NEXT(a_step_fills_output, s1_go, out_valid_r)

endmodule
